/* hw/rtl/wbss_pkg.sv */
// Package for the wildcard byte signature scanner: constants, payload and config types.
`timescale 1ns / 1ps

package wbss_pkg;

	localparam int MAX_PATTERN_BYTES = 24;
	localparam int LEN_W             = 5;
	localparam int ADDR_W            = 64;
	localparam int OFFSET_W          = 32;

	typedef enum logic [2:0] {
		REG_PAT_LOW       = 3'd0,
		REG_PAT_MID       = 3'd1,
		REG_PAT_HIGH      = 3'd2,
		REG_WC_MASK       = 3'd3,
		REG_PAT_LEN       = 3'd4,
		REG_REGION_START  = 3'd5,
		REG_RESULT_OFFSET = 3'd6,
		REG_MULTI_MATCH   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_last;
	} scan_in_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
		logic              scan_done;
	} scan_out_t;

	// Signature aligned to window age: entry a is compared with the byte a places back.
	typedef struct packed {
		logic [MAX_PATTERN_BYTES-1:0][7:0] pat_al;
		logic [MAX_PATTERN_BYTES-1:0]      care_al;
		logic [LEN_W-1:0]                  len_eff;
		logic [ADDR_W-1:0]                 addr_base;
		logic                              multi;
	} scan_cfg_t;

endpackage

/* hw/rtl/wildcard_byte_signature_scanner_core.sv */
// Top level of the wildcard byte signature scanner: input stage, window compare, result register.
`timescale 1ns / 1ps

// Takes one region byte per clock and reports signature matches. A request is
// registered on acceptance in the input stage, compared against the last 24
// bytes under the wildcard mask as it leaves that stage, and any result is then
// registered in the output register; a new byte can be taken every cycle while
// the output is free or being drained, and a stalled output holds the input
// stage. The final byte of a region always yields one result with scan_done set
// and clears the window, byte count and match bookkeeping. Register writes are
// accepted every cycle and apply to bytes accepted from the next cycle on.
module wildcard_byte_signature_scanner_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wbss_pkg::scan_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wbss_pkg::scan_out_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  wbss_pkg::cfg_reg_t   cfg_index,
	input  logic [63:0]          cfg_data
);
	import wbss_pkg::*;

	scan_cfg_t scan_cfg;

	logic     valid_s1;
	scan_in_t item_s1;
	logic     adv;

	logic [MAX_PATTERN_BYTES-1:0][7:0] win_q;
	logic [MAX_PATTERN_BYTES-1:0][7:0] win_new;
	logic [ADDR_W-1:0]                 seen_q;   // bytes seen including the one in stage 1
	logic [ADDR_W-1:0]                 nas_q;
	logic                              taken_q;

	logic                         enough;
	logic [MAX_PATTERN_BYTES-1:0] mism;
	logic                         hit;
	logic [ADDR_W-1:0]            start_idx;
	logic                         report;

	logic      out_valid_q;
	scan_out_t out_data_q;

	wbss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.scan_cfg  (scan_cfg)
	);

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign win_new = {win_q[MAX_PATTERN_BYTES-2:0], item_s1.data_byte};

	always_comb begin
		for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
			mism[a] = scan_cfg.care_al[a] && (win_new[a] != scan_cfg.pat_al[a]);
		end
	end

	assign enough = (|seen_q[ADDR_W-1:LEN_W]) || (seen_q[LEN_W-1:0] >= scan_cfg.len_eff);
	assign hit    = (scan_cfg.len_eff != '0) && enough && !(|mism);
	assign start_idx = seen_q - ADDR_W'(scan_cfg.len_eff);

	always_comb begin
		if (scan_cfg.multi) begin
			report = hit && (start_idx >= nas_q);
		end else begin
			report = hit && !taken_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			seen_q  <= ADDR_W'(1);
			nas_q   <= '0;
			taken_q <= 1'b0;
		end else if (adv) begin
			if (item_s1.region_last) begin
				win_q   <= '0;
				seen_q  <= ADDR_W'(1);
				nas_q   <= '0;
				taken_q <= 1'b0;
			end else begin
				win_q  <= win_new;
				seen_q <= seen_q + ADDR_W'(1);
				if (report) begin
					// next allowed start is match start plus length, i.e. bytes seen
					if (scan_cfg.multi) begin
						nas_q <= seen_q;
					end else begin
						taken_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && (report || item_s1.region_last)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (report || item_s1.region_last)) begin
			out_data_q.found         <= report;
			out_data_q.match_address <= report ? (scan_cfg.addr_base + seen_q) : '0;
			out_data_q.scan_done     <= item_s1.region_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_no_found_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.found |-> out_data_q.match_address == '0)
		else $error("result without match carries an address");

	a_result_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.found || out_data_q.scan_done)
		else $error("empty result delivered");

	a_region_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.region_last |=> seen_q == ADDR_W'(1) && nas_q == '0 && !taken_q)
		else $error("scan state not cleared after final byte");

	a_taken_falls_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(taken_q) |-> $past(adv && item_s1.region_last))
		else $error("single-mode flag cleared mid-region");

	a_accept_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted request lost at input stage");
`endif

endmodule

/* hw/rtl/wbss_cfg.sv */
// Configuration registers and the derived, window-aligned signature for the scanner.
`timescale 1ns / 1ps

module wbss_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  wbss_pkg::cfg_reg_t     cfg_index,
	input  logic [63:0]            cfg_data,
	output wbss_pkg::scan_cfg_t    scan_cfg
);
	import wbss_pkg::*;

	logic [63:0]                  pat_low_q;
	logic [63:0]                  pat_mid_q;
	logic [63:0]                  pat_high_q;
	logic [MAX_PATTERN_BYTES-1:0] wc_mask_q;
	logic [LEN_W-1:0]             pat_len_q;
	logic [ADDR_W-1:0]            region_start_q;
	logic [OFFSET_W-1:0]          result_offset_q;
	logic                         multi_q;

	logic [MAX_PATTERN_BYTES-1:0][7:0] sig_bytes;
	scan_cfg_t                         derived;
	scan_cfg_t                         derived_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q       <= '0;
			pat_mid_q       <= '0;
			pat_high_q      <= '0;
			wc_mask_q       <= '0;
			pat_len_q       <= LEN_W'(1);
			region_start_q  <= '0;
			result_offset_q <= '0;
			multi_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAT_LOW:       pat_low_q       <= cfg_data;
				REG_PAT_MID:       pat_mid_q       <= cfg_data;
				REG_PAT_HIGH:      pat_high_q      <= cfg_data;
				REG_WC_MASK:       wc_mask_q       <= cfg_data[MAX_PATTERN_BYTES-1:0];
				REG_PAT_LEN:       pat_len_q       <= cfg_data[LEN_W-1:0];
				REG_REGION_START:  region_start_q  <= cfg_data;
				REG_RESULT_OFFSET: result_offset_q <= cfg_data[OFFSET_W-1:0];
				REG_MULTI_MATCH:   multi_q         <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	assign sig_bytes = {pat_high_q, pat_mid_q, pat_low_q};

	always_comb begin
		logic [LEN_W-1:0] idx;
		derived         = '0;
		derived.len_eff = (pat_len_q > LEN_W'(MAX_PATTERN_BYTES)) ?
			LEN_W'(MAX_PATTERN_BYTES) : pat_len_q;
		for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
			idx = derived.len_eff - LEN_W'(a) - LEN_W'(1);
			if (LEN_W'(a) < derived.len_eff) begin
				derived.pat_al[a]  = sig_bytes[idx];
				derived.care_al[a] = !wc_mask_q[idx];
			end
		end
		// match start index is bytes seen minus length, so fold the length in here
		derived.addr_base = region_start_q
			+ {{(ADDR_W-OFFSET_W){result_offset_q[OFFSET_W-1]}}, result_offset_q}
			- ADDR_W'(derived.len_eff);
		derived.multi = multi_q;
	end

	// Derived copy is registered from the registers in the next cycle; no request can use it sooner.
	always_ff @(posedge clk) begin
		derived_q <= derived;
	end

	assign scan_cfg = derived_q;

endmodule
